FILE: hw/rtl/arpc_pkg.sv
//------------------------------------------------------------------------------
// arpc_pkg
// Shared types and constants of the ARP cache resolver.
//------------------------------------------------------------------------------
`default_nettype none
package arpc_pkg;
    localparam int CACHE_ENTRIES = 16;
    localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);

    localparam logic [1:0] ST_PENDING  = 2'd0;
    localparam logic [1:0] ST_COMPLETE = 2'd1;
    localparam logic [1:0] ST_TIMEOUT  = 2'd2;

    localparam logic [2:0] MODE_PKT     = 3'd0;
    localparam logic [2:0] MODE_RESOLVE = 3'd1;
    localparam logic [2:0] MODE_TICK    = 3'd2;
    localparam logic [2:0] MODE_DELETE  = 3'd3;
    localparam logic [2:0] MODE_CLEAR   = 3'd4;

    localparam logic [1:0] REG_MY_IP   = 2'd0;
    localparam logic [1:0] REG_MY_MAC  = 2'd1;
    localparam logic [1:0] REG_CLIFE   = 2'd2;
    localparam logic [1:0] REG_PLIFE   = 2'd3;

    localparam logic [47:0] MAC_BCAST = 48'hFFFF_FFFF_FFFF;

    // one cache entry as stored in memory (valid kept in flops)
    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
        logic [1:0]  st;
        logic [31:0] stamp;
    } t_entry;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_entry           wdata;
    } t_mem_wr;
endpackage
`default_nettype wire

FILE: hw/rtl/arpc_table.sv
//------------------------------------------------------------------------------
// arpc_table
// Entry memory: one write port, one registered read port.
//------------------------------------------------------------------------------
`default_nettype none
module arpc_table
    import arpc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire t_mem_wr          i_wr,
    input  wire logic [IDX_W-1:0] i_raddr,
    output t_entry                o_rdata
);
    t_entry r_mem [CACHE_ENTRIES];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.waddr] <= i_wr.wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: hw/rtl/arp_cache_resolver_core.sv
//------------------------------------------------------------------------------
// arp_cache_resolver_core
// ARP cache with request/reply handling, resolve, aging, delete and clear.
//------------------------------------------------------------------------------
// Usage: one request on the i_ channel (valid/ready) yields exactly one
// result on the o_ channel (valid/ready). Configuration registers are
// written through i_cfg_we / i_cfg_index / i_cfg_data while idle.
// Each request walks the entry memory once, one entry per cycle over its
// single read port; a clear skips the walk and goes straight to the finish
// state, which raises its result. A changed entry is written back in the
// finish cycle and adds no time. One request is in flight at a time: the
// next request is taken only once the machine has left its output state
// and is idle again. If the receiver stalls, the result holds in the output
// register and no new request is accepted. Reset clears all valid bits, the
// seconds counter and restores lifetimes 600 and 180; the memory needs no
// clearing pass.
//------------------------------------------------------------------------------
`default_nettype none
module arp_cache_resolver_core
    import arpc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [47:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [2:0]  i_mode,
    input  wire logic [15:0] i_arp_opcode,
    input  wire logic [47:0] i_sender_mac,
    input  wire logic [31:0] i_sender_ip,
    input  wire logic [31:0] i_target_ip,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_action,
    output logic [2:0]       o_status_code,
    output logic [1:0]       o_pkt_opcode,
    output logic [47:0]      o_pkt_sender_mac,
    output logic [31:0]      o_pkt_sender_ip,
    output logic [47:0]      o_pkt_target_mac,
    output logic [31:0]      o_pkt_target_ip
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]  r_state, n_state;
    logic [31:0] r_my_ip;
    logic [47:0] r_my_mac;
    logic [15:0] r_clife, r_plife;
    logic [31:0] r_now;
    logic [CACHE_ENTRIES-1:0] r_vld;

    logic [2:0]  r_mode;
    logic [15:0] r_opc;
    logic [47:0] r_smac;
    logic [31:0] r_sip, r_tip;

    logic [CNT_W-1:0] r_cnt;      // read address counter
    logic             r_rd_vld;   // read data valid this cycle
    logic [IDX_W-1:0] r_rd_idx;   // index of data on read port
    logic             r_found;
    logic [IDX_W-1:0] r_hit_idx;
    logic [1:0]       r_hit_st;
    logic             r_free;
    logic [IDX_W-1:0] r_free_idx;

    t_entry           w_rdata;
    t_mem_wr          w_wr;
    logic [IDX_W-1:0] w_raddr;

    arpc_table u_table (
        .i_clk   (i_clk),
        .i_wr    (w_wr),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_ready = (r_state == S_IDLE) && (!o_valid || i_ready);
    assign w_raddr = r_cnt[IDX_W-1:0];

    wire w_acc = i_valid && o_ready;
    wire w_last_rd = (r_cnt == CNT_W'(CACHE_ENTRIES - 1));

    // lookup key: resolve/delete use target, packets use sender
    wire [31:0] w_key = (r_mode == MODE_PKT) ? r_sip : r_tip;
    wire        w_match = r_rd_vld && r_vld[r_rd_idx] && (w_rdata.ip == w_key);
    wire [15:0] w_life = (w_rdata.st == ST_COMPLETE) ? r_clife : r_plife;
    wire [31:0] w_age = r_now - w_rdata.stamp;
    wire        w_expire = r_rd_vld && r_vld[r_rd_idx] && (w_rdata.st != ST_TIMEOUT)
                           && (w_age > {16'd0, w_life});

    // final decision
    logic        d_wr, d_set_vld, d_clr_vld, d_full;
    logic [IDX_W-1:0] d_idx;
    t_entry      d_ent;
    logic [1:0]  d_action, d_popc;
    logic [2:0]  d_status;
    logic [47:0] d_psmac, d_ptmac;
    logic [31:0] d_psip, d_ptip;

    always_comb begin
        d_wr = 1'b0; d_set_vld = 1'b0; d_clr_vld = 1'b0; d_full = 1'b0;
        d_idx = r_found ? r_hit_idx : r_free_idx;
        d_ent = '{ip: r_sip, mac: r_smac, st: ST_COMPLETE, stamp: r_now};
        d_action = 2'd0; d_popc = 2'd0; d_status = 3'd0;
        d_psmac = '0; d_psip = '0; d_ptmac = '0; d_ptip = '0;
        unique case (r_mode)
            MODE_PKT: begin
                if (r_opc == 16'd1) begin
                    if (r_found || r_free) begin
                        d_wr = 1'b1; d_set_vld = 1'b1;
                    end else begin
                        d_status = 3'd4;
                    end
                    if (r_tip == r_my_ip) begin
                        d_action = 2'd2; d_popc = 2'd2;
                        d_psmac = r_my_mac; d_psip = r_my_ip;
                        d_ptmac = r_smac; d_ptip = r_sip;
                    end
                end else if (r_opc == 16'd2) begin
                    if (r_sip == r_tip) begin
                        d_status = 3'd2;
                    end else if (r_found) begin
                        d_wr = 1'b1;
                    end
                end else begin
                    d_status = 3'd3;
                end
            end
            MODE_RESOLVE: begin
                d_ent = '{ip: r_tip, mac: MAC_BCAST, st: ST_PENDING, stamp: r_now};
                d_action = 2'd1; d_popc = 2'd1;
                d_psmac = r_my_mac; d_psip = r_sip;
                d_ptmac = MAC_BCAST; d_ptip = r_tip;
                if (r_sip != r_tip) begin
                    if (r_found && r_hit_st == ST_PENDING) begin
                        d_status = 3'd1;
                        d_action = 2'd0; d_popc = 2'd0;
                        d_psmac = '0; d_psip = '0; d_ptmac = '0; d_ptip = '0;
                    end else if (r_found || r_free) begin
                        d_wr = 1'b1; d_set_vld = 1'b1;
                    end else begin
                        d_status = 3'd4;
                    end
                end
            end
            MODE_DELETE: begin
                if (r_found) d_clr_vld = 1'b1;
                else d_status = 3'd5;
            end
            default: begin
            end
        endcase
        d_full = d_wr;
    end

    // memory write: aging during scan, update at finish
    always_comb begin
        w_wr.we = 1'b0;
        w_wr.waddr = r_rd_idx;
        w_wr.wdata = w_rdata;
        if (r_state == S_SCAN && r_mode == MODE_TICK && w_expire) begin
            w_wr.we = 1'b1;
            w_wr.wdata.st = ST_TIMEOUT;
        end else if (r_state == S_FIN && d_full) begin
            w_wr.we = 1'b1;
            w_wr.waddr = d_idx;
            w_wr.wdata = d_ent;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_acc) n_state = (i_mode == MODE_CLEAR) ? S_FIN : S_SCAN;
            S_SCAN: if (r_rd_vld && !r_cnt[CNT_W-1] && r_cnt == CNT_W'(CACHE_ENTRIES))
                        n_state = S_FIN;
            S_FIN:  n_state = S_OUT;
            S_OUT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        if (r_state == S_SCAN && r_rd_vld && r_rd_idx == IDX_W'(CACHE_ENTRIES - 1))
            n_state = S_FIN;
    end

    // control and scan bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_my_ip <= '0; r_my_mac <= '0;
            r_clife <= 16'd600; r_plife <= 16'd180;
            r_now <= '0; r_vld <= '0;
            r_cnt <= '0; r_rd_vld <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_MY_IP:  r_my_ip  <= i_cfg_data[31:0];
                    REG_MY_MAC: r_my_mac <= i_cfg_data;
                    REG_CLIFE:  r_clife  <= i_cfg_data[15:0];
                    REG_PLIFE:  r_plife  <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (o_valid && i_ready) o_valid <= 1'b0;
            if (w_acc) begin
                r_cnt <= '0;
                r_rd_vld <= 1'b0;
                if (i_mode == MODE_TICK) r_now <= r_now + 32'd1;
                if (i_mode == MODE_CLEAR) r_vld <= '0;
            end
            if (r_state == S_SCAN) begin
                r_rd_vld <= !w_last_rd || !r_rd_vld ? (r_cnt < CNT_W'(CACHE_ENTRIES)) : 1'b1;
                if (r_cnt < CNT_W'(CACHE_ENTRIES)) r_cnt <= r_cnt + CNT_W'(1);
            end
            if (r_state == S_FIN) begin
                if (d_set_vld) r_vld[d_idx] <= 1'b1;
                if (d_clr_vld) r_vld[r_hit_idx] <= 1'b0;
                o_valid <= 1'b1;
            end
        end
    end

    // request capture, scan results and output register
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_mode <= i_mode; r_opc <= i_arp_opcode; r_smac <= i_sender_mac;
            r_sip <= i_sender_ip; r_tip <= i_target_ip;
            r_found <= 1'b0; r_free <= 1'b0;
            r_hit_idx <= '0; r_free_idx <= '0; r_hit_st <= ST_PENDING;
        end
        if (r_state == S_SCAN) begin
            r_rd_idx <= r_cnt[IDX_W-1:0];
            if (w_match && !r_found) begin
                r_found <= 1'b1; r_hit_idx <= r_rd_idx; r_hit_st <= w_rdata.st;
            end
            if (r_rd_vld && !r_vld[r_rd_idx] && !r_free) begin
                r_free <= 1'b1; r_free_idx <= r_rd_idx;
            end
        end
        if (r_state == S_FIN) begin
            o_action <= d_action; o_status_code <= d_status; o_pkt_opcode <= d_popc;
            o_pkt_sender_mac <= d_psmac; o_pkt_sender_ip <= d_psip;
            o_pkt_target_mac <= d_ptmac; o_pkt_target_ip <= d_ptip;
        end
    end

`ifndef ASSERT_OFF
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |=> o_valid) else $error("result not raised");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready) else $error("accept while busy");
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid && $stable(o_status_code))
        else $error("result dropped");
`endif
endmodule
`default_nettype wire
